/* hw/rtl/cpcr_pkg.sv */
// ----------------------------------------------------------------------------
// cpcr_pkg
// Shared types and constants for the circle pair collision resolve core.
// ----------------------------------------------------------------------------
package cpcr_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 33;
    localparam int ST_SQRT_IN  = 3;
    localparam int ST_MATH     = ST_SQRT_IN + SQRT_STAGES;
    localparam int ST_DIV_IN   = ST_MATH + 6;
    localparam int ST_DIV_OUT  = ST_DIV_IN + DIV_STAGES;
    localparam int ST_OUT      = ST_DIV_OUT + 1;

    localparam logic [16:0] COEF_ONE   = 17'd65536;
    localparam logic [16:0] SHARE_HALF = 17'd32768;
    localparam logic [16:0] COEF_RESET = 17'd49152;

    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic               nx;
        logic               ny;
        logic [31:0]        sum;
        logic               pin1;
        logic               pin2;
        logic               go;
        logic               tz;
        logic               hit;
        logic [31:0]        span;
    } t_side;

endpackage

/* hw/rtl/cpcr_sqrt.sv */
// ----------------------------------------------------------------------------
// cpcr_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cpcr_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);

    logic [33:0] r_rem  [0:cpcr_pkg::SQRT_STAGES-1];
    logic [31:0] r_root [0:cpcr_pkg::SQRT_STAGES-1];
    logic [63:0] r_val  [0:cpcr_pkg::SQRT_STAGES-1];
    logic [33:0] n_rem  [0:cpcr_pkg::SQRT_STAGES-1];
    logic [31:0] n_root [0:cpcr_pkg::SQRT_STAGES-1];
    logic [63:0] n_val  [0:cpcr_pkg::SQRT_STAGES-1];

    always_comb begin
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] val;
        logic [35:0] t;
        logic [35:0] trial;
        logic        ge;
        for (int i = 0; i < cpcr_pkg::SQRT_STAGES; i++) begin
            if (i == 0) begin
                rem  = '0;
                root = '0;
                val  = i_val;
            end else begin
                rem  = r_rem[i-1];
                root = r_root[i-1];
                val  = r_val[i-1];
            end
            t         = {rem, val[63:62]};
            trial     = {2'b00, root, 2'b01};
            ge        = (t >= trial);
            n_rem[i]  = ge ? 34'(t - trial) : t[33:0];
            n_root[i] = {root[30:0], ge};
            n_val[i]  = {val[61:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < cpcr_pkg::SQRT_STAGES; i++) begin
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
                r_val[i]  <= n_val[i];
            end
        end
    end

    assign o_root = r_root[cpcr_pkg::SQRT_STAGES-1];

endmodule

/* hw/rtl/cpcr_div.sv */
// ----------------------------------------------------------------------------
// cpcr_div
// Pipelined restoring divider, 64 by 32 bits, one quotient bit per stage.
// The quotient must fit in 33 bits.
// ----------------------------------------------------------------------------
module cpcr_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [32:0] o_quo
);

    logic [31:0] r_rem [0:cpcr_pkg::DIV_STAGES-1];
    logic [32:0] r_lo  [0:cpcr_pkg::DIV_STAGES-1];
    logic [31:0] r_den [0:cpcr_pkg::DIV_STAGES-1];
    logic [31:0] n_rem [0:cpcr_pkg::DIV_STAGES-1];
    logic [32:0] n_lo  [0:cpcr_pkg::DIV_STAGES-1];
    logic [31:0] n_den [0:cpcr_pkg::DIV_STAGES-1];

    always_comb begin
        logic [31:0] rem;
        logic [32:0] lo;
        logic [31:0] den;
        logic [32:0] t;
        logic        ge;
        for (int i = 0; i < cpcr_pkg::DIV_STAGES; i++) begin
            if (i == 0) begin
                rem = {1'b0, i_num[63:33]};
                lo  = i_num[32:0];
                den = i_den;
            end else begin
                rem = r_rem[i-1];
                lo  = r_lo[i-1];
                den = r_den[i-1];
            end
            t        = {rem, lo[32]};
            ge       = (t >= {1'b0, den});
            n_rem[i] = ge ? 32'(t - {1'b0, den}) : t[31:0];
            n_lo[i]  = {lo[31:0], ge};
            n_den[i] = den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < cpcr_pkg::DIV_STAGES; i++) begin
                r_rem[i] <= n_rem[i];
                r_lo[i]  <= n_lo[i];
                r_den[i] <= n_den[i];
            end
        end
    end

    assign o_quo = r_lo[cpcr_pkg::DIV_STAGES-1];

endmodule

/* hw/rtl/circle_pair_collision_resolve_core.sv */
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve_core
// Resolves overlap of one circle pair per transaction by pushing centers apart.
// ----------------------------------------------------------------------------
// Throughput: one pair per cycle; a 32-stage square root and 33-stage dividers
// set the depth, and the whole pipeline holds while the result is not taken.
// Reset clears all valid bits and loads the response coefficient with 0.75.
module circle_pair_collision_resolve_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [16:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // first_x, first_y, first_radius, first_mass,
    // second_x, second_y, second_radius, second_mass, 4 zero bits
    input  logic [255:0] i_s_axis_tdata,
    // first_pinned, first_solid, second_pinned, second_solid
    input  logic [3:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // new_first_x, new_first_y, new_second_x, new_second_y
    output logic [127:0] o_m_axis_tdata,
    // contact
    output logic [0:0]   o_m_axis_tuser
);

    logic        en;
    logic [16:0] r_coef;
    logic [16:0] coef_sat;
    logic        r_vld [0:cpcr_pkg::ST_OUT];

    logic [255:0] r_data0;
    logic [3:0]   r_user0;

    cpcr_pkg::t_side r_side [1:cpcr_pkg::ST_DIV_OUT];
    cpcr_pkg::t_side n_side1;
    cpcr_pkg::t_side n_side_hit;
    cpcr_pkg::t_side n_side_span;

    logic [30:0]  r_m1_1, r_m1_2;
    logic [31:0]  r_tot_1, r_tot_2;
    logic [63:0]  r_sx, r_sy, r_s2;
    logic [64:0]  r_d2;
    logic [31:0]  sqrt_root;
    logic [32:0]  share_quo;

    logic [48:0]  r_prod;
    logic [16:0]  r_r1_36, r_r1_37;
    logic [16:0]  n_r1;
    logic [31:0]  r_push;
    logic [49:0]  push_sum;
    logic [48:0]  r_p1, r_p2;
    logic [49:0]  p1_sum, p2_sum;
    logic [31:0]  r_a1, r_a2;
    logic [63:0]  r_mxa, r_mya, r_mxb, r_myb;
    logic [63:0]  r_nxa, r_nya, r_nxb, r_nyb;
    logic [32:0]  q_xa, q_ya, q_xb, q_yb;

    logic signed [31:0] r_ox1, r_oy1, r_ox2, r_oy2;
    logic               r_ocontact;
    logic signed [31:0] n_ox1, n_oy1, n_ox2, n_oy2;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                   input logic [32:0] mag,
                                                   input logic neg);
        logic signed [34:0] off;
        logic signed [34:0] s;
        begin
            off = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
            s   = 35'(base) + off;
            if (s > 35'sd2147483647) begin
                sat_add = 32'sh7FFFFFFF;
            end else if (s < -35'sd2147483648) begin
                sat_add = 32'sh80000000;
            end else begin
                sat_add = s[31:0];
            end
        end
    endfunction

    assign en              = !r_vld[cpcr_pkg::ST_OUT] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;
    assign coef_sat        = (r_coef > cpcr_pkg::COEF_ONE) ? cpcr_pkg::COEF_ONE : r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= cpcr_pkg::COEF_RESET;
        end else if (i_cfg_valid) begin
            r_coef <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= cpcr_pkg::ST_OUT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k <= cpcr_pkg::ST_OUT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 1: differences and flags
    always_comb begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [31:0]        tot;
        dx = 33'($signed(r_data0[31:0])) - 33'($signed(r_data0[157:126]));
        dy = 33'($signed(r_data0[63:32])) - 33'($signed(r_data0[189:158]));
        tot = {1'b0, r_data0[125:95]} + {1'b0, r_data0[251:221]};
        n_side1      = '0;
        n_side1.x1   = r_data0[31:0];
        n_side1.y1   = r_data0[63:32];
        n_side1.x2   = r_data0[157:126];
        n_side1.y2   = r_data0[189:158];
        n_side1.nx   = dx[32];
        n_side1.ny   = dy[32];
        n_side1.ax   = dx[32] ? 32'(-dx) : dx[31:0];
        n_side1.ay   = dy[32] ? 32'(-dy) : dy[31:0];
        n_side1.sum  = {1'b0, r_data0[94:64]} + {1'b0, r_data0[220:190]};
        n_side1.pin1 = r_user0[0];
        n_side1.pin2 = r_user0[2];
        n_side1.go   = r_user0[1] && r_user0[3] && !(r_user0[0] && r_user0[2]);
        n_side1.tz   = (tot == '0);
    end

    always_comb begin
        n_side_hit      = r_side[cpcr_pkg::ST_SQRT_IN];
        n_side_hit.hit  = r_side[cpcr_pkg::ST_SQRT_IN].go
            && !r_d2[64] && (r_d2[63:0] < r_s2);
        n_side_span      = r_side[cpcr_pkg::ST_MATH];
        n_side_span.span = sqrt_root;
    end

    cpcr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_d2[63:0]),
        .o_root (sqrt_root)
    );

    cpcr_div u_div_share (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({17'd0, r_m1_2, 16'd0}),
        .i_den (r_tot_2),
        .o_quo (share_quo)
    );

    always_comb begin
        if (r_side[cpcr_pkg::ST_MATH].pin1) begin
            n_r1 = cpcr_pkg::COEF_ONE;
        end else if (r_side[cpcr_pkg::ST_MATH].pin2) begin
            n_r1 = '0;
        end else if (r_side[cpcr_pkg::ST_MATH].tz) begin
            n_r1 = cpcr_pkg::SHARE_HALF;
        end else begin
            n_r1 = share_quo[16:0];
        end
    end

    assign push_sum = {1'b0, r_prod} + 50'd65536;
    assign p1_sum   = {1'b0, r_p1} + 50'd32768;
    assign p2_sum   = {1'b0, r_p2} + 50'd32768;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data0 <= i_s_axis_tdata;
            r_user0 <= i_s_axis_tuser;

            r_side[1] <= n_side1;
            for (int k = 2; k <= cpcr_pkg::ST_DIV_OUT; k++) begin
                if (k == cpcr_pkg::ST_SQRT_IN + 1) begin
                    r_side[k] <= n_side_hit;
                end else if (k == cpcr_pkg::ST_MATH + 1) begin
                    r_side[k] <= n_side_span;
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end

            r_m1_1  <= r_data0[125:95];
            r_tot_1 <= {1'b0, r_data0[125:95]} + {1'b0, r_data0[251:221]};
            r_m1_2  <= r_m1_1;
            r_tot_2 <= r_tot_1;

            r_sx <= r_side[1].ax * r_side[1].ax;
            r_sy <= r_side[1].ay * r_side[1].ay;
            r_s2 <= r_side[2].sum * r_side[2].sum;
            r_d2 <= {1'b0, r_sx} + {1'b0, r_sy};

            r_prod  <= 32'(r_side[cpcr_pkg::ST_MATH].sum - sqrt_root) * coef_sat;
            r_r1_36 <= n_r1;
            r_push  <= push_sum[48:17];
            r_r1_37 <= r_r1_36;
            r_p1    <= r_push * 17'(cpcr_pkg::COEF_ONE - r_r1_37);
            r_p2    <= r_push * r_r1_37;
            r_a1    <= p1_sum[47:16];
            r_a2    <= p2_sum[47:16];
            r_mxa   <= r_side[cpcr_pkg::ST_DIV_IN-2].ax * r_a1;
            r_mya   <= r_side[cpcr_pkg::ST_DIV_IN-2].ay * r_a1;
            r_mxb   <= r_side[cpcr_pkg::ST_DIV_IN-2].ax * r_a2;
            r_myb   <= r_side[cpcr_pkg::ST_DIV_IN-2].ay * r_a2;
            r_nxa   <= r_mxa + 64'(r_side[cpcr_pkg::ST_DIV_IN-1].span >> 1);
            r_nya   <= r_mya + 64'(r_side[cpcr_pkg::ST_DIV_IN-1].span >> 1);
            r_nxb   <= r_mxb + 64'(r_side[cpcr_pkg::ST_DIV_IN-1].span >> 1);
            r_nyb   <= r_myb + 64'(r_side[cpcr_pkg::ST_DIV_IN-1].span >> 1);

            r_ox1      <= n_ox1;
            r_oy1      <= n_oy1;
            r_ox2      <= n_ox2;
            r_oy2      <= n_oy2;
            r_ocontact <= r_side[cpcr_pkg::ST_DIV_OUT].hit;
        end
    end

    cpcr_div u_div_xa (
        .i_clk (i_clk), .i_en (en), .i_num (r_nxa),
        .i_den (r_side[cpcr_pkg::ST_DIV_IN].span), .o_quo (q_xa)
    );

    cpcr_div u_div_ya (
        .i_clk (i_clk), .i_en (en), .i_num (r_nya),
        .i_den (r_side[cpcr_pkg::ST_DIV_IN].span), .o_quo (q_ya)
    );

    cpcr_div u_div_xb (
        .i_clk (i_clk), .i_en (en), .i_num (r_nxb),
        .i_den (r_side[cpcr_pkg::ST_DIV_IN].span), .o_quo (q_xb)
    );

    cpcr_div u_div_yb (
        .i_clk (i_clk), .i_en (en), .i_num (r_nyb),
        .i_den (r_side[cpcr_pkg::ST_DIV_IN].span), .o_quo (q_yb)
    );

    always_comb begin
        cpcr_pkg::t_side s;
        logic            mv;
        s     = r_side[cpcr_pkg::ST_DIV_OUT];
        mv    = s.hit && (s.span != '0);
        n_ox1 = s.x1;
        n_oy1 = s.y1;
        n_ox2 = s.x2;
        n_oy2 = s.y2;
        if (mv && !s.pin1) begin
            n_ox1 = sat_add(s.x1, q_xa, s.nx);
            n_oy1 = sat_add(s.y1, q_ya, s.ny);
        end
        if (mv && !s.pin2) begin
            n_ox2 = sat_add(s.x2, q_xb, !s.nx);
            n_oy2 = sat_add(s.y2, q_yb, !s.ny);
        end
    end

    assign o_m_axis_tvalid = r_vld[cpcr_pkg::ST_OUT];
    assign o_m_axis_tdata  = {r_oy2, r_ox2, r_oy1, r_ox1};
    assign o_m_axis_tuser  = r_ocontact;

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circle pair collision resolve core. Streams
// directed and random circle pairs under bursty input and stalling output,
// predicts each resolved pair in the bench and compares every result in order.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic signed [31:0] x1, y1, x2, y2;
        logic [30:0]        rad1, m1, rad2, m2;
        logic               pin1, sol1, pin2, sol2;
    } t_pair;

    typedef struct {
        logic signed [31:0] nx1, ny1, nx2, ny2;
        logic               contact;
    } t_resolved;

    typedef struct {
        t_pair     p;
        logic      typed;
        t_resolved r;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [16:0]  i_cfg_data;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [255:0] i_s_axis_tdata;
    logic [3:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [127:0] o_m_axis_tdata;
    logic [0:0]   o_m_axis_tuser;

    logic [16:0]  coef_shadow;
    t_resolved    resolved_q[$];
    int           errors;
    int           pairs_sent;
    int           burst_left;

    circle_pair_collision_resolve_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("circle_pair_collision_resolve_core test failed");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint sat_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint axis_offset(longint d, longint unsigned amt,
                                           longint unsigned span);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = (mag * amt + span / 2) / span;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_resolved pass_thru(t_pair p, logic contact);
        t_resolved r;
        r.nx1 = p.x1;
        r.ny1 = p.y1;
        r.nx2 = p.x2;
        r.ny2 = p.y2;
        r.contact = contact;
        return r;
    endfunction

    function automatic t_resolved resolve_pair(t_pair p, logic [16:0] coef_reg);
        t_resolved       r;
        longint          dx, dy;
        longint unsigned ax, ay, sum, span, coef, push, total, r1, r2, amt1, amt2;
        logic [64:0]     dist2;
        r = pass_thru(p, 1'b0);
        if (p.sol1 && p.sol2 && !(p.pin1 && p.pin2)) begin
            dx = longint'(p.x1) - longint'(p.x2);
            dy = longint'(p.y1) - longint'(p.y2);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            dist2 = {1'b0, ax * ax} + {1'b0, ay * ay};
            sum = longint'(p.rad1) + longint'(p.rad2);
            if (!dist2[64] && dist2[63:0] < sum * sum) begin
                span = int_sqrt(dist2[63:0]);
                r.contact = 1'b1;
                if (span != 0) begin
                    coef = (coef_reg > cpcr_pkg::COEF_ONE) ? 65536 : coef_reg;
                    push = ((sum - span) * coef + 65536) >> 17;
                    total = longint'(p.m1) + longint'(p.m2);
                    if (p.pin1) r1 = 65536;
                    else if (p.pin2) r1 = 0;
                    else if (total == 0) r1 = 32768;
                    else r1 = (longint'(p.m1) << 16) / total;
                    r2 = 65536 - r1;
                    amt1 = (push * r2 + 32768) >> 16;
                    amt2 = (push * r1 + 32768) >> 16;
                    if (!p.pin1) begin
                        r.nx1 = 32'(sat_coord(longint'(p.x1) + axis_offset(dx, amt1, span)));
                        r.ny1 = 32'(sat_coord(longint'(p.y1) + axis_offset(dy, amt1, span)));
                    end
                    if (!p.pin2) begin
                        r.nx2 = 32'(sat_coord(longint'(p.x2) - axis_offset(dx, amt2, span)));
                        r.ny2 = 32'(sat_coord(longint'(p.y2) - axis_offset(dy, amt2, span)));
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic t_pair mk_pair(int x1, int y1, int x2, int y2, int rad1,
                                      int rad2, int m1, int m2, logic [3:0] fl);
        t_pair p;
        p.x1 = x1; p.y1 = y1; p.x2 = x2; p.y2 = y2;
        p.rad1 = 31'(rad1); p.rad2 = 31'(rad2); p.m1 = 31'(m1); p.m2 = 31'(m2);
        {p.sol2, p.pin2, p.sol1, p.pin1} = fl;
        return p;
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        int    kind;
        int    spread;
        kind = $urandom_range(0, 9);
        p.x1 = $urandom; p.y1 = $urandom; p.x2 = $urandom; p.y2 = $urandom;
        p.rad1 = 31'($urandom); p.rad2 = 31'($urandom);
        p.m1 = 31'($urandom); p.m2 = 31'($urandom);
        {p.sol2, p.pin2, p.sol1, p.pin1} = 4'($urandom);
        if (kind < 8) begin
            spread = 1 << $urandom_range(2, 24);
            if (kind == 7) p.x1 = $urandom_range(0, 1) ? 32'sh7fff_fff0 : 32'sh8000_0010;
            p.x2 = p.x1 + $signed($urandom_range(0, 2 * spread)) - spread;
            p.y2 = p.y1 + $signed($urandom_range(0, 2 * spread)) - spread;
            p.rad1 = 31'($urandom_range(0, spread));
            p.rad2 = 31'($urandom_range(0, spread));
            p.m1 = 31'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 1 << 20));
            p.m2 = 31'($urandom_range(0, 3) == 0 ? 0 : $urandom);
            p.sol1 = $urandom_range(0, 15) != 0;
            p.sol2 = $urandom_range(0, 15) != 0;
            p.pin1 = $urandom_range(0, 4) == 0;
            p.pin2 = $urandom_range(0, 4) == 0;
            if ($urandom_range(0, 15) == 0) begin
                p.x2 = p.x1;
                p.y2 = p.y1;
            end
        end
        return p;
    endfunction

    task automatic send_pair(t_pair p, logic typed, t_resolved r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, p.m2, p.rad2, p.y2, p.x2, p.m1, p.rad1, p.y1, p.x1};
        i_s_axis_tuser  <= {p.sol2, p.pin2, p.sol1, p.pin1};
        do @(posedge i_clk); while (!o_s_axis_tready);
        resolved_q.insert(resolved_q.size(), typed ? r : resolve_pair(p, coef_shadow));
        pairs_sent++;
    endtask

    task automatic write_coef(logic [16:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        coef_shadow = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (resolved_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (resolved_q.size() == 0) begin
                $error("unexpected result: tdata=%h tuser=%b", o_m_axis_tdata, o_m_axis_tuser);
                errors++;
            end else begin
                t_resolved e;
                e = resolved_q.pop_front();
                if (o_m_axis_tdata[31:0] !== e.nx1) begin
                    $error("new_first_x: expected %0d actual %0d", e.nx1,
                           $signed(o_m_axis_tdata[31:0]));
                    errors++;
                end
                if (o_m_axis_tdata[63:32] !== e.ny1) begin
                    $error("new_first_y: expected %0d actual %0d", e.ny1,
                           $signed(o_m_axis_tdata[63:32]));
                    errors++;
                end
                if (o_m_axis_tdata[95:64] !== e.nx2) begin
                    $error("new_second_x: expected %0d actual %0d", e.nx2,
                           $signed(o_m_axis_tdata[95:64]));
                    errors++;
                end
                if (o_m_axis_tdata[127:96] !== e.ny2) begin
                    $error("new_second_y: expected %0d actual %0d", e.ny2,
                           $signed(o_m_axis_tdata[127:96]));
                    errors++;
                end
                if (o_m_axis_tuser[0] !== e.contact) begin
                    $error("contact: expected %0b actual %0b", e.contact, o_m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    int rx_cycle;
    int hold_left;
    bit hold_done;
    always @(posedge i_clk) begin
        rx_cycle++;
        if (!hold_done && pairs_sent >= 300) begin
            hold_done = 1'b1;
            hold_left = 500;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            case ((rx_cycle >> 8) % 3)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= $urandom_range(0, 3) != 0;
                default: i_m_axis_tready <= $urandom_range(0, 2) == 0;
            endcase
        end
    end

    t_row        rows[$];
    logic [16:0] coef_set[5];
    t_pair       p;

    initial begin
        errors = 0;
        pairs_sent = 0;
        burst_left = 0;
        rx_cycle = 0;
        hold_left = 0;
        hold_done = 1'b0;
        coef_shadow = cpcr_pkg::COEF_RESET;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // not collidable, extremes pass through
        p = mk_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 4'b0111);
        rows.insert(rows.size(), '{p, 1'b1, pass_thru(p, 1'b0)});
        p = mk_pair(0, 0, 1, 0, 100, 100, 1, 1, 4'b1101);
        rows.insert(rows.size(), '{p, 1'b1, pass_thru(p, 1'b0)});
        // both pinned
        p = mk_pair(0, 0, 1, 0, 100, 100, 1, 1, 4'b1111);
        rows.insert(rows.size(), '{p, 1'b1, pass_thru(p, 1'b0)});
        // no overlap: exact touch
        p = mk_pair(0, 0, 200, 0, 100, 100, 1, 1, 4'b1010);
        rows.insert(rows.size(), '{p, 1'b1, pass_thru(p, 1'b0)});
        // coincident centres
        p = mk_pair(-5, 7, -5, 7, 10, 10, 3, 3, 4'b1010);
        rows.insert(rows.size(), '{p, 1'b1, pass_thru(p, 1'b1)});
        // huge distance with maximal radii
        p = mk_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                    32'h7fffffff, 32'h7fffffff, 1, 1, 4'b1010);
        rows.insert(rows.size(), '{p, 1'b1, pass_thru(p, 1'b0)});
        // overlap, equal masses, first pinned, second pinned, zero mass
        rows.insert(rows.size(),
                    '{mk_pair(0, 0, 65536, 0, 65536, 65536, 65536, 65536, 4'b1010),
                      1'b0, pass_thru(p, 1'b0)});
        rows.insert(rows.size(), '{mk_pair(0, 0, 3000, 4000, 9000, 9000, 7, 9, 4'b1011),
                                   1'b0, pass_thru(p, 1'b0)});
        rows.insert(rows.size(), '{mk_pair(0, 0, -3000, 4000, 9000, 9000, 7, 9, 4'b1110),
                                   1'b0, pass_thru(p, 1'b0)});
        rows.insert(rows.size(), '{mk_pair(10, -10, -10, 10, 500, 500, 0, 0, 4'b1010),
                                   1'b0, pass_thru(p, 1'b0)});
        rows.insert(rows.size(),
                    '{mk_pair(1, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              32'h7fffffff, 4'b1010), 1'b0, pass_thru(p, 1'b0)});
        // saturation at both ends
        rows.insert(rows.size(),
                    '{mk_pair(32'h7ffffff0, 32'h80000010, 32'h7fffff00, 32'h80000100,
                              32'h10000000, 32'h10000000, 1, 1, 4'b1010),
                      1'b0, pass_thru(p, 1'b0)});
        rows.insert(rows.size(),
                    '{mk_pair(32'h80000000, 32'h7fffffff, 32'h80000001, 32'h7ffffffe,
                              32'h7fffffff, 0, 0, 32'h7fffffff, 4'b1010),
                      1'b0, pass_thru(p, 1'b0)});
        foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].r);
        drain();

        coef_set = '{17'd0, cpcr_pkg::COEF_ONE, 17'h1ffff, 17'd1, 17'd0};
        coef_set[4] = 17'($urandom_range(0, 65536));
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_coef(coef_set[ph - 1]);
            for (int k = 0; k < (ph == 0 ? 600 : 280); k++) begin
                send_pair(rand_pair(), 1'b0, pass_thru(p, 1'b0));
            end
            drain();
        end
        if (errors == 0 && resolved_q.size() == 0) begin
            $display("circle_pair_collision_resolve_core test passed");
        end else begin
            $display("circle_pair_collision_resolve_core test failed");
        end
        $finish;
    end
endmodule

/* files.f */
hw/rtl/cpcr_pkg.sv
hw/rtl/cpcr_sqrt.sv
hw/rtl/cpcr_div.sv
hw/rtl/circle_pair_collision_resolve_core.sv
dv/tb.sv
